// ----- sv/tlde_pkg.sv -----
// Shared types and constants of the tree LCA and distance engine.
package tlde_pkg;

	localparam int NODES_DEF  = 1024;
	localparam int LEVELS_DEF = 10;
	localparam int NODE_W     = 10;
	localparam int PATH_W     = 11;

	localparam logic [PATH_W-1:0] PATH_MAX  = 11'd2046;
	localparam logic [PATH_W-1:0] PATH_NONE = 11'd2047;

	typedef enum logic [1:0] {
		OP_ROOT   = 2'd0,
		OP_ATTACH = 2'd1,
		OP_QUERY  = 2'd2,
		OP_IGNORE = 2'd3
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [NODE_W-1:0] node_a;
		logic [NODE_W-1:0] node_b;
	} cmd_t;

	typedef struct packed {
		logic [NODE_W-1:0] ancestor_node;
		logic [PATH_W-1:0] path_length;
	} rsp_t;

endpackage

// ----- sv/tlde_if.sv -----
// Valid/ready channel interfaces for commands and query results.
interface tlde_cmd_if import tlde_pkg::*; ();
	logic valid;
	logic ready;
	cmd_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tlde_rsp_if import tlde_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- sv/tlde_ram.sv -----
// Simple dual-port synchronous RAM with one write port and one registered read port.
module tlde_ram import tlde_pkg::*; #(
	parameter int WIDTH = NODE_W + 1,
	parameter int DEPTH = NODES_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- sv/tree_lca_distance_engine_unit.sv -----
// Top level of the tree LCA and distance engine: sequencer around two memories.
//
//  Channel | Role   | Payload                       | Transaction
//  --------+--------+-------------------------------+------------------------------------
//  cmd     | sink   | op, node_a, node_b            | one command: set root, attach, query
//  rsp     | source | ancestor_node, path_length    | one answer for each in-range query
//
//  The single read port of the ancestor memory paces every command: a set-root command
//  writes one level per pass through ST_ROOT, an attach or lift level passes through
//  ST_ATT_RD or ST_Q_LIFT, and also through ST_ATT_WR or ST_Q_LIFTW when it takes a
//  lookup, and each level of the top-down walk passes through ST_Q_DX, ST_Q_DY, ST_Q_DZ.
//  Reset clears only the sequencer and the result valid flag; both memories hold garbage
//  until the tree is built, and no clearing pass runs.
//  A finished answer waits in the output register while the next command is taken; the
//  sequencer only stalls at the end of a query if that register is still occupied.
module tree_lca_distance_engine_unit import tlde_pkg::*; #(
	parameter int NODES  = NODES_DEF,
	parameter int LEVELS = LEVELS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	tlde_cmd_if.sink      cmd,
	tlde_rsp_if.source    rsp
);

	// Node indexes, entry width (one extra code for "no ancestor"), depth and level widths.
	localparam int NAW       = $clog2(NODES);
	localparam int EW        = $clog2(NODES + 1);
	localparam int DW        = NAW;
	localparam int LW        = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int ANC_DEPTH = NODES * LEVELS;
	localparam int AAW       = $clog2(ANC_DEPTH);
	localparam int LNW       = (DW + 2 > 12) ? DW + 2 : 12;

	localparam logic [EW-1:0] NO_ANC    = EW'(NODES);
	localparam logic [DW-1:0] DEPTH_MAX = DW'(NODES - 1);
	localparam logic [LW-1:0] LVL_LAST  = LW'(LEVELS - 1);

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ROOT,
		ST_ATT_D,
		ST_ATT_RD,
		ST_ATT_WR,
		ST_Q_DA,
		ST_Q_DB,
		ST_Q_LIFT,
		ST_Q_LIFTW,
		ST_Q_CMP,
		ST_Q_DX,
		ST_Q_DY,
		ST_Q_DZ,
		ST_Q_UP,
		ST_Q_UPW,
		ST_Q_LD,
		ST_Q_LEN,
		ST_Q_OUT
	} state_t;

	state_t            state_q;
	logic [LW-1:0]     lvl_q;
	logic              rsp_valid_q;
	rsp_t              rsp_data_q;

	// Working registers. During an attach x_q walks the chain of ancestors of the parent.
	logic [EW-1:0]     a_q;
	logic [EW-1:0]     b_q;
	logic [EW-1:0]     x_q;
	logic [EW-1:0]     y_q;
	logic [EW-1:0]     px_q;
	logic [EW-1:0]     l_q;
	logic [DW-1:0]     dep_q;
	logic [DW-1:0]     da_q;
	logic [DW-1:0]     db_q;
	logic [LEVELS-1:0] diff_q;
	logic [NODE_W-1:0] res_anc_q;
	logic [PATH_W-1:0] res_len_q;

	// Memory ports.
	logic              anc_we;
	logic [AAW-1:0]    anc_waddr;
	logic [EW-1:0]     anc_wdata;
	logic [AAW-1:0]    anc_raddr;
	logic [EW-1:0]     anc_rdata;
	logic              dep_we;
	logic [NAW-1:0]    dep_waddr;
	logic [DW-1:0]     dep_wdata;
	logic [NAW-1:0]    dep_raddr;
	logic [DW-1:0]     dep_rdata;

	logic              cmd_acc;
	logic              cmd_ok;
	logic              lvl_last;
	logic              x_ok;
	logic              y_ok;
	logic              out_free;
	logic [EW-1:0]     anc_norm;
	logic [EW-1:0]     py;
	logic [DW-1:0]     dep_inc;
	logic [LNW-1:0]    len_raw;
	logic [PATH_W-1:0] len_clamped;

	// Entry (v, i) of the ancestor memory holds the 2^i-ancestor of node v.
	function automatic logic [AAW-1:0] anc_addr(input logic [EW-1:0] v, input logic [LW-1:0] l);
		return AAW'(v[NAW-1:0]) * AAW'(LEVELS) + AAW'(l);
	endfunction

	tlde_ram #(
		.WIDTH (EW),
		.DEPTH (ANC_DEPTH)
	) u_anc_ram (
		.clk   (clk),
		.we    (anc_we),
		.waddr (anc_waddr),
		.wdata (anc_wdata),
		.raddr (anc_raddr),
		.rdata (anc_rdata)
	);

	tlde_ram #(
		.WIDTH (DW),
		.DEPTH (NODES)
	) u_dep_ram (
		.clk   (clk),
		.we    (dep_we),
		.waddr (dep_waddr),
		.wdata (dep_wdata),
		.raddr (dep_raddr),
		.rdata (dep_rdata)
	);

	assign cmd_acc  = cmd.valid && cmd.ready;
	assign cmd_ok   = (32'(cmd.data.node_a) < NODES) && (32'(cmd.data.node_b) < NODES);
	assign lvl_last = (lvl_q == LVL_LAST);
	assign x_ok     = (x_q != NO_ANC);
	assign y_ok     = (y_q != NO_ANC);
	assign out_free = !rsp_valid_q || rsp.ready;

	// Any stored code at or above NODES reads as "no ancestor".
	assign anc_norm = (anc_rdata < NO_ANC) ? anc_rdata : NO_ANC;
	assign py       = y_ok ? anc_norm : NO_ANC;
	assign dep_inc  = (dep_rdata >= DEPTH_MAX) ? DEPTH_MAX : dep_rdata + DW'(1);

	// Path length: depth(a) + depth(b) - 2 * depth(lca), clamped to the output range.
	assign len_raw = LNW'(da_q) + LNW'(db_q) - LNW'({dep_rdata, 1'b0});
	always_comb begin
		if (len_raw[LNW-1]) begin
			len_clamped = '0;
		end else if (len_raw > LNW'(PATH_MAX)) begin
			len_clamped = PATH_MAX;
		end else begin
			len_clamped = PATH_W'(len_raw);
		end
	end

	assign cmd.ready = (state_q == ST_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	// Memory addressing and write enables. Every write lands before any read of the same
	// entry is issued, so no forwarding is needed.
	always_comb begin
		anc_we    = 1'b0;
		anc_waddr = anc_addr(a_q, lvl_q);
		anc_wdata = NO_ANC;
		anc_raddr = anc_addr(x_q, lvl_q);
		dep_we    = 1'b0;
		dep_waddr = a_q[NAW-1:0];
		dep_wdata = dep_q;
		dep_raddr = a_q[NAW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				// An attach needs the parent's depth, a query the first node's depth.
				dep_raddr = (cmd.data.op == OP_ATTACH) ? NAW'(cmd.data.node_b)
				                                       : NAW'(cmd.data.node_a);
			end
			ST_ROOT: begin
				anc_we = 1'b1;
				if (lvl_last) begin
					dep_we    = 1'b1;
					dep_wdata = '0;
				end
			end
			ST_ATT_D: begin
				anc_we    = 1'b1;
				anc_waddr = anc_addr(a_q, '0);
				anc_wdata = b_q;
				if (LEVELS == 1) begin
					dep_we    = 1'b1;
					dep_wdata = dep_inc;
				end
			end
			ST_ATT_RD: begin
				anc_raddr = anc_addr(x_q, lvl_q - LW'(1));
				if (!x_ok) begin
					anc_we = 1'b1;
					dep_we = lvl_last;
				end
			end
			ST_ATT_WR: begin
				anc_we    = 1'b1;
				anc_wdata = anc_norm;
				dep_we    = lvl_last;
			end
			ST_Q_DA: begin
				dep_raddr = b_q[NAW-1:0];
			end
			ST_Q_DB: begin
			end
			ST_Q_LIFT: begin
				anc_raddr = anc_addr(y_q, lvl_q);
			end
			ST_Q_LIFTW, ST_Q_CMP, ST_Q_DZ, ST_Q_UPW, ST_Q_LEN, ST_Q_OUT: begin
			end
			ST_Q_DX: begin
				anc_raddr = anc_addr(x_q, lvl_q);
			end
			ST_Q_DY: begin
				anc_raddr = anc_addr(y_q, lvl_q);
			end
			ST_Q_UP: begin
				anc_raddr = anc_addr(x_q, '0);
			end
			ST_Q_LD: begin
				dep_raddr = l_q[NAW-1:0];
			end
		endcase
	end

	// Sequencer state, level counter and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			lvl_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// A new answer takes the output register in the cycle the old one leaves it.
			if ((state_q == ST_Q_OUT) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					lvl_q <= '0;
					if (cmd_acc && cmd_ok) begin
						unique case (cmd.data.op)
							OP_ROOT:   state_q <= ST_ROOT;
							OP_ATTACH: state_q <= ST_ATT_D;
							OP_QUERY:  state_q <= ST_Q_DA;
							OP_IGNORE: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_ROOT: begin
					if (lvl_last) begin
						state_q <= ST_IDLE;
					end else begin
						lvl_q <= lvl_q + LW'(1);
					end
				end
				ST_ATT_D: begin
					if (LEVELS == 1) begin
						state_q <= ST_IDLE;
					end else begin
						lvl_q   <= LW'(1);
						state_q <= ST_ATT_RD;
					end
				end
				ST_ATT_RD: begin
					if (x_ok) begin
						state_q <= ST_ATT_WR;
					end else if (lvl_last) begin
						state_q <= ST_IDLE;
					end else begin
						lvl_q <= lvl_q + LW'(1);
					end
				end
				ST_ATT_WR: begin
					if (lvl_last) begin
						state_q <= ST_IDLE;
					end else begin
						lvl_q   <= lvl_q + LW'(1);
						state_q <= ST_ATT_RD;
					end
				end
				ST_Q_DA: state_q <= ST_Q_DB;
				ST_Q_DB: begin
					lvl_q   <= '0;
					state_q <= ST_Q_LIFT;
				end
				ST_Q_LIFT: begin
					if (diff_q[lvl_q] && y_ok) begin
						state_q <= ST_Q_LIFTW;
					end else if (lvl_last) begin
						state_q <= ST_Q_CMP;
					end else begin
						lvl_q <= lvl_q + LW'(1);
					end
				end
				ST_Q_LIFTW: begin
					if (lvl_last) begin
						state_q <= ST_Q_CMP;
					end else begin
						lvl_q   <= lvl_q + LW'(1);
						state_q <= ST_Q_LIFT;
					end
				end
				ST_Q_CMP: begin
					if (x_q == y_q) begin
						state_q <= ST_Q_LD;
					end else begin
						lvl_q   <= LVL_LAST;
						state_q <= ST_Q_DX;
					end
				end
				ST_Q_DX: state_q <= ST_Q_DY;
				ST_Q_DY: state_q <= ST_Q_DZ;
				ST_Q_DZ: begin
					if (lvl_q == '0) begin
						state_q <= ST_Q_UP;
					end else begin
						lvl_q   <= lvl_q - LW'(1);
						state_q <= ST_Q_DX;
					end
				end
				ST_Q_UP:  state_q <= ST_Q_UPW;
				ST_Q_UPW: state_q <= ST_Q_LD;
				ST_Q_LD: begin
					state_q <= (l_q == NO_ANC) ? ST_Q_OUT : ST_Q_LEN;
				end
				ST_Q_LEN: state_q <= ST_Q_OUT;
				ST_Q_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	// Datapath registers; they carry no reset.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_acc) begin
					a_q <= EW'(cmd.data.node_a);
					b_q <= EW'(cmd.data.node_b);
				end
			end
			ST_ATT_D: begin
				dep_q <= dep_inc;
				x_q   <= b_q;
			end
			ST_ATT_WR: begin
				x_q <= anc_norm;
			end
			ST_Q_DA: begin
				da_q <= dep_rdata;
			end
			ST_Q_DB: begin
				// The shallower node goes to x; y is lifted by the depth difference.
				db_q <= dep_rdata;
				if (da_q > dep_rdata) begin
					x_q    <= b_q;
					y_q    <= a_q;
					diff_q <= LEVELS'(da_q - dep_rdata);
				end else begin
					x_q    <= a_q;
					y_q    <= b_q;
					diff_q <= LEVELS'(dep_rdata - da_q);
				end
			end
			ST_Q_LIFTW: begin
				y_q <= anc_norm;
			end
			ST_Q_CMP: begin
				l_q <= x_q;
			end
			ST_Q_DY: begin
				px_q <= x_ok ? anc_norm : NO_ANC;
			end
			ST_Q_DZ: begin
				if (px_q != py) begin
					x_q <= px_q;
					y_q <= py;
				end
			end
			ST_Q_UPW: begin
				l_q <= x_ok ? anc_norm : NO_ANC;
			end
			ST_Q_LD: begin
				if (l_q == NO_ANC) begin
					res_anc_q <= '0;
					res_len_q <= PATH_NONE;
				end else begin
					res_anc_q <= NODE_W'(l_q);
				end
			end
			ST_Q_LEN: begin
				res_len_q <= len_clamped;
			end
			ST_Q_OUT: begin
				if (out_free) begin
					rsp_data_q.ancestor_node <= res_anc_q;
					rsp_data_q.path_length   <= res_len_q;
				end
			end
			ST_ROOT, ST_ATT_RD, ST_Q_LIFT, ST_Q_DX, ST_Q_UP: begin
			end
		endcase
	end

	// A result only appears right after the sequencer leaves the output state.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_Q_OUT))
		else $error("result valid raised outside the output state");

	// The level counter never addresses a level beyond the table.
	assert property (@(posedge clk) disable iff (!arst_n)
		lvl_q <= LVL_LAST)
		else $error("level counter out of range");

	// The ancestor memory only ever receives a node index or the no-ancestor code.
	assert property (@(posedge clk) disable iff (!arst_n)
		anc_we |-> (anc_wdata <= NO_ANC))
		else $error("ancestor write with an invalid code");

	// The no-common-ancestor answer always names node zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (rsp_data_q.path_length == PATH_NONE))
			|-> (rsp_data_q.ancestor_node == '0))
		else $error("no-ancestor answer with a nonzero node");

	// An accepted in-range query starts with the depth reads.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_acc && cmd_ok && (cmd.data.op == OP_QUERY)) |=> (state_q == ST_Q_DA))
		else $error("query did not start");

endmodule

// ----- tb/lca_scoreboard_pkg.sv -----
// Scoreboard class that predicts lowest-common-ancestor answers and checks them.
package lca_scoreboard_pkg;
	import tlde_pkg::*;

	localparam int NODES  = NODES_DEF;
	localparam int LEVELS = LEVELS_DEF;
	localparam int ANC_W  = NODE_W + 1;
	localparam logic [ANC_W-1:0] NO_ANC = ANC_W'(NODES);

	class lca_scoreboard;
		// Shadow copy of the lifting table and the depth table.
		bit [ANC_W-1:0]  lift_tbl [NODES][LEVELS];
		bit [NODE_W-1:0] depth_tbl [NODES];
		rsp_t            answers_due[$];
		int              mismatches;
		int              taken;
		int              answered;
		int              disjoint_answers;
		int              deepest;

		// One 2^lvl step up; anything out of range means there is no ancestor.
		function bit [ANC_W-1:0] hop(bit [ANC_W-1:0] v, int lvl);
			bit [ANC_W-1:0] e;
			if (v >= NODES || lvl >= LEVELS)
				return NO_ANC;
			e = lift_tbl[v][lvl];
			return (e < NODES) ? e : NO_ANC;
		endfunction

		function rsp_t predict_query(int a, int b);
			rsp_t           r;
			int             da, db, diff, len;
			bit [ANC_W-1:0] x, y, px, py, l;
			da = depth_tbl[a];
			db = depth_tbl[b];
			x = ANC_W'(a);
			y = ANC_W'(b);
			if (da > db) begin
				x = ANC_W'(b);
				y = ANC_W'(a);
				diff = da - db;
			end else begin
				diff = db - da;
			end
			// Bring the deeper node up to the depth of the shallower one.
			for (int i = 0; i < LEVELS; i++)
				if (diff[i])
					y = hop(y, i);
			if (x == y) begin
				l = x;
			end else begin
				for (int i = LEVELS; i > 0; i--) begin
					px = hop(x, i - 1);
					py = hop(y, i - 1);
					if (px != py) begin
						x = px;
						y = py;
					end
				end
				l = hop(x, 0);
			end
			if (l >= NODES) begin
				r.ancestor_node = '0;
				r.path_length = PATH_NONE;
				disjoint_answers++;
			end else begin
				len = da + db - 2 * int'(depth_tbl[l]);
				if (len < 0)
					len = 0;
				if (len > int'(PATH_MAX))
					len = int'(PATH_MAX);
				r.ancestor_node = NODE_W'(l);
				r.path_length = PATH_W'(len);
			end
			return r;
		endfunction

		// Updates the shadow tree for one accepted command and queues any answer it owes.
		function void note_command(cmd_t c);
			bit [NODE_W-1:0] d;
			int              a, b;
			a = c.node_a;
			b = c.node_b;
			taken++;
			case (c.op)
				OP_ROOT: begin
					for (int i = 0; i < LEVELS; i++)
						lift_tbl[a][i] = NO_ANC;
					depth_tbl[a] = '0;
				end
				OP_ATTACH: begin
					d = depth_tbl[b];
					lift_tbl[a][0] = ANC_W'(b);
					for (int i = 1; i < LEVELS; i++)
						lift_tbl[a][i] = hop(hop(ANC_W'(a), i - 1), i - 1);
					depth_tbl[a] = (d >= NODE_W'(NODES - 1)) ? d : d + 1'b1;
					if (int'(depth_tbl[a]) > deepest)
						deepest = depth_tbl[a];
				end
				OP_QUERY: begin
					answers_due = {answers_due, predict_query(a, b)};
				end
				default: begin
				end
			endcase
		endfunction

		task report(string msg);
			mismatches++;
			$display("ERROR: %s", msg);
		endtask

		task check_answer(rsp_t got);
			rsp_t want;
			if (answers_due.size() == 0) begin
				report($sformatf("answer (%0d, %0d) arrived with no query outstanding",
					got.ancestor_node, got.path_length));
				return;
			end
			want = answers_due.pop_front();
			answered++;
			if (got.ancestor_node !== want.ancestor_node)
				report($sformatf("answer %0d: ancestor_node %0d, expected %0d",
					answered, got.ancestor_node, want.ancestor_node));
			if (got.path_length !== want.path_length)
				report($sformatf("answer %0d: path_length %0d, expected %0d",
					answered, got.path_length, want.path_length));
		endtask
	endclass

endpackage

// ----- tb/tb.sv -----
// Top-level testbench of the tree LCA and distance engine.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tlde_pkg::*;
	import lca_scoreboard_pkg::*;

	// The longest gap with no transaction on either channel is a full query
	// plus one sender gap and one receiver stall.
	// The limit below is many times that.
	localparam int IDLE_LIMIT  = 2000;
	// After the last expected answer, wait out roughly one more query latency.
	localparam int TAIL_CYCLES = 100;
	// Length of the deep chain; long enough that lifts use the top level.
	localparam int CHAIN_LEN   = 540;

	logic clk;
	logic arst_n;

	tlde_cmd_if cmd_ch ();
	tlde_rsp_if rsp_ch ();

	tree_lca_distance_engine_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	lca_scoreboard sb = new;

	// Nodes that have been placed by a root or attach command. Queries and
	// attach parents are drawn only from these, so that no unwritten table
	// entry is ever read.
	bit in_tree [NODES];
	int members[$];

	// When a side is calm it does not idle at all; each side flips in and
	// out of calm now and then so that long back-to-back stretches occur.
	bit src_calm;
	bit sink_calm;
	int quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_member();
		return members[$urandom_range(0, members.size() - 1)];
	endfunction

	// Drives one command transaction, after a random number of idle cycles,
	// and returns at the clock edge where it is accepted.
	task automatic send_cmd(op_t op, int a, int b);
		cmd_t c;
		int   gap;
		gap = src_calm ? 0 : $urandom_range(0, 14);
		if ($urandom_range(0, 39) == 0)
			src_calm = !src_calm;
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		c.op = op;
		c.node_a = NODE_W'(a);
		c.node_b = NODE_W'(b);
		cmd_ch.data <= c;
		cmd_ch.valid <= 1'b1;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		if ((op == OP_ROOT || op == OP_ATTACH) && !in_tree[a]) begin
			in_tree[a] = 1'b1;
			members = {members, a};
		end
	endtask

	// The result receiver. Before each answer it holds ready low for a random
	// number of cycles, then keeps it high until an answer is taken.
	initial begin
		int stall;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = sink_calm ? 0 : $urandom_range(0, 14);
			if ($urandom_range(0, 39) == 0)
				sink_calm = !sink_calm;
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!(rsp_ch.valid && rsp_ch.ready))
				@(posedge clk);
		end
	end

	// Both channels are sampled at the rising edge. Every accepted command
	// updates the shadow tree, every accepted answer is checked against the
	// oldest queued prediction. The watchdog counts edges with no transaction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready)
				sb.check_answer(rsp_ch.data);
			if (cmd_ch.valid && cmd_ch.ready)
				sb.note_command(cmd_ch.data);
			if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("ERROR: no transaction for %0d cycles", IDLE_LIMIT);
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		int useful;
		int r;
		int a;
		int j;
		int tmp;
		int chain [NODES];

		arst_n <= 1'b0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening. A small tree is built from extreme and alternating
		// bit patterns, then queried across branches, along a branch, and on a
		// node with itself. A second root gives two trees whose nodes have no
		// common ancestor. A node attached to itself breaks the table on
		// purpose, and re-rooting a node that has children leaves stale
		// entries below it; the answers must still follow the table exactly.
		send_cmd(OP_IGNORE, 1023, 1023);
		send_cmd(OP_ROOT, 0, 1023);
		send_cmd(OP_ATTACH, 1, 0);
		send_cmd(OP_ATTACH, 2, 1);
		send_cmd(OP_ATTACH, 1023, 2);
		send_cmd(OP_ATTACH, 512, 0);
		send_cmd(OP_QUERY, 1023, 512);
		send_cmd(OP_QUERY, 512, 1023);
		send_cmd(OP_QUERY, 0, 0);
		send_cmd(OP_QUERY, 1023, 1);
		send_cmd(OP_QUERY, 0, 1023);
		send_cmd(OP_ROOT, 1022, 0);
		send_cmd(OP_ATTACH, 341, 1022);
		send_cmd(OP_QUERY, 341, 1023);
		send_cmd(OP_QUERY, 1022, 0);
		send_cmd(OP_IGNORE, 0, 0);
		send_cmd(OP_ATTACH, 682, 1022);
		send_cmd(OP_ATTACH, 682, 682);
		send_cmd(OP_QUERY, 682, 341);
		send_cmd(OP_ROOT, 1, 682);
		send_cmd(OP_QUERY, 2, 0);
		send_cmd(OP_QUERY, 2, 1);
		send_cmd(OP_ATTACH, 1, 1023);
		send_cmd(OP_QUERY, 2, 1023);

		// Random forest. Mostly well-formed growth and queries between placed
		// nodes; now and then a new root, a re-attach of a placed node (which
		// corrupts its subtree), and ignored commands as noise.
		useful = 0;
		while (useful < 60) begin
			r = $urandom_range(0, 99);
			if (r < 6) begin
				send_cmd(OP_IGNORE, $urandom_range(0, NODES - 1), $urandom_range(0, NODES - 1));
			end else begin
				useful++;
				if (r < 10)
					send_cmd(OP_ROOT, $urandom_range(0, NODES - 1), $urandom_range(0, NODES - 1));
				else if (r < 45)
					send_cmd(OP_ATTACH, $urandom_range(0, NODES - 1), pick_member());
				else if (r < 50)
					send_cmd(OP_ATTACH, pick_member(), pick_member());
				else
					send_cmd(OP_QUERY, pick_member(), pick_member());
			end
		end

		// Deep chain. Node ids drawn in random order are threaded into one
		// long path, so a query between the ends lifts through the top level.
		// Queries are sprinkled along the way.
		for (int i = 0; i < NODES; i++)
			chain[i] = i;
		for (int i = NODES - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = chain[i];
			chain[i] = chain[j];
			chain[j] = tmp;
		end
		send_cmd(OP_ROOT, chain[0], $urandom_range(0, NODES - 1));
		for (int k = 1; k < CHAIN_LEN; k++) begin
			send_cmd(OP_ATTACH, chain[k], chain[k - 1]);
			if ($urandom_range(0, 15) == 0)
				send_cmd(OP_QUERY, chain[$urandom_range(0, k)], chain[$urandom_range(0, k)]);
		end
		send_cmd(OP_QUERY, chain[0], chain[CHAIN_LEN - 1]);
		send_cmd(OP_QUERY, chain[CHAIN_LEN - 1], chain[0]);

		// Corrupted chain ends: the deepest node points at itself and the
		// chain's root is hung below it, so the walk meets a cycle.
		send_cmd(OP_ATTACH, chain[CHAIN_LEN - 1], chain[CHAIN_LEN - 1]);
		send_cmd(OP_ATTACH, chain[0], chain[CHAIN_LEN - 1]);
		send_cmd(OP_QUERY, chain[0], chain[CHAIN_LEN / 2]);

		// Side branches hung off the deep chain give real forks far from the
		// root, with long paths between them.
		repeat (15) begin
			a = chain[$urandom_range(1, CHAIN_LEN - 1)];
			send_cmd(OP_ATTACH, a, chain[$urandom_range(0, CHAIN_LEN - 1)]);
			send_cmd(OP_QUERY, a, chain[$urandom_range(0, CHAIN_LEN - 1)]);
		end

		cmd_ch.valid <= 1'b0;

		while (sb.answers_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.answers_due.size() != 0)
			sb.report($sformatf("%0d answers never arrived", sb.answers_due.size()));

		$display("Run covered %0d commands and %0d checked answers, %0d with no common ancestor.",
			sb.taken, sb.answered, sb.disjoint_answers);
		$display("Deepest depth reached was %0d; %0d node ids were placed in a tree.",
			sb.deepest, members.size());
		if (sb.mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
